### hw/rtl/hmbs_pkg.sv
// hmbs_pkg: shared types, constants and a helper function for the height map sampler.
// Used by hmbs_front, hmbs_back, heightmap_bilinear_sampler and the testbench. No dependencies.
package hmbs_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int HEIGHT_BITS = 24;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int DIM_W       = $clog2(MAX_WIDTH) + 1;
    localparam int CX_W        = 8;
    localparam int INV_W       = 24;
    localparam int CNT_W       = ADDR_W + 1;

    // command codes
    localparam logic [2:0] CMD_WRITE  = 3'd0;
    localparam logic [2:0] CMD_READ   = 3'd1;
    localparam logic [2:0] CMD_SAMPLE = 3'd2;
    localparam logic [2:0] CMD_FILL   = 3'd3;
    localparam logic [2:0] CMD_SCAN   = 3'd4;

    // configuration register indexes
    localparam logic [2:0] REG_GRID_WIDTH  = 3'd0;
    localparam logic [2:0] REG_GRID_HEIGHT = 3'd1;
    localparam logic [2:0] REG_INV_BLOCK_W = 3'd2;
    localparam logic [2:0] REG_INV_BLOCK_H = 3'd3;

    typedef enum logic [2:0] {
        OP_WRITE  = 3'd0,
        OP_READ   = 3'd1,
        OP_SAMPLE = 3'd2,
        OP_FILL   = 3'd3,
        OP_SCAN   = 3'd4,
        OP_NOP    = 3'd5
    } op_t;

    typedef struct packed {
        op_t                            op;
        logic [CX_W-1:0]                cx;
        logic [CX_W-1:0]                cz;
        logic signed [HEIGHT_BITS-1:0]  hv;
        logic signed [31:0]             wx;
        logic signed [31:0]             wz;
    } item_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

    // scaled coordinate p (Q.32) -> grid coordinate Q.16 clamped to [0, (n-1)<<16]
    function automatic logic [23:0] grid_clamp(input logic signed [56:0] p,
                                               input logic [DIM_W-1:0] n);
        logic [DIM_W-1:0] nm1;
        logic [23:0]      lim;
        logic [39:0]      g;
        nm1 = n - DIM_W'(1);
        lim = {nm1[7:0], 16'h0000};
        g   = p[55:16];
        if (p <= 57'sd0)
            grid_clamp = 24'd0;
        else if (g > {16'h0000, lim})
            grid_clamp = lim;
        else
            grid_clamp = g[23:0];
    endfunction

endpackage

### hw/rtl/hmbs_ram.sv
// hmbs_ram: generic single-port RAM with registered read.
// No dependencies.
module hmbs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end

endmodule

### hw/rtl/hmbs_front.sv
// hmbs_front: accepts input words, decodes the command, queues them for the back end.
// Depends on hmbs_pkg.
module hmbs_front import hmbs_pkg::*; (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [2:0]                    command,
    input  logic [CX_W-1:0]               cell_x,
    input  logic [CX_W-1:0]               cell_z,
    input  logic signed [HEIGHT_BITS-1:0] height_value,
    input  logic signed [31:0]            world_x,
    input  logic signed [31:0]            world_z,
    input  back_status_t                  bstat,
    output logic                          q_valid,
    output item_t                         q_item,
    input  logic                          q_pop
);

    item_t      q_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    item_t      dec;
    logic       push;

    always_comb
    begin
        dec.cx = cell_x;
        dec.cz = cell_z;
        dec.hv = height_value;
        dec.wx = world_x;
        dec.wz = world_z;
        case (command)
            CMD_WRITE:  dec.op = OP_WRITE;
            CMD_READ:   dec.op = OP_READ;
            CMD_SAMPLE: dec.op = OP_SAMPLE;
            CMD_FILL:   dec.op = OP_FILL;
            CMD_SCAN:   dec.op = OP_SCAN;
            default:    dec.op = OP_NOP;
        endcase
    end

    assign in_stall = (count_reg == 2'd2) || bstat.clearing;
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= dec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (q_pop && q_valid)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(q_pop && q_valid);
        end
    end

endmodule

### hw/rtl/hmbs_back.sv
// hmbs_back: executes queued commands against the height store and drives the result word.
// Depends on hmbs_pkg and hmbs_ram.
module hmbs_back import hmbs_pkg::*; (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [DIM_W-1:0]               eff_w,
    input  logic [DIM_W-1:0]               eff_h,
    input  logic [INV_W-1:0]               inv_w,
    input  logic [INV_W-1:0]               inv_h,
    input  logic                           q_valid,
    input  item_t                          q_item,
    output logic                           q_pop,
    output back_status_t                   bstat,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [HEIGHT_BITS-1:0]  result_height,
    output logic signed [HEIGHT_BITS-1:0]  min_height,
    output logic signed [HEIGHT_BITS-1:0]  max_height,
    output logic                           status
);

    typedef enum logic [22:0] {
        S_CLEAR = 23'd1 << 0,  S_IDLE = 23'd1 << 1,  S_DISP = 23'd1 << 2,
        S_WR    = 23'd1 << 3,  S_RD0  = 23'd1 << 4,  S_RD1  = 23'd1 << 5,
        S_FILL  = 23'd1 << 6,  S_SCAN = 23'd1 << 7,  S_SCANW = 23'd1 << 8,
        S_MULX  = 23'd1 << 9,  S_MULZ = 23'd1 << 10, S_CLZ  = 23'd1 << 11,
        S_ROWS  = 23'd1 << 12, S_RA   = 23'd1 << 13, S_RB   = 23'd1 << 14,
        S_RC    = 23'd1 << 15, S_RD   = 23'd1 << 16, S_L0   = 23'd1 << 17,
        S_L1    = 23'd1 << 18, S_L2   = 23'd1 << 19, S_L3   = 23'd1 << 20,
        S_L4    = 23'd1 << 21, S_FIN  = 23'd1 << 22
    } state_t;

    state_t                        state_reg;
    item_t                         item_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [CNT_W-1:0]              n_reg;
    logic [ADDR_W-1:0]             addr_reg;
    logic signed [56:0]            prod_reg;
    logic [23:0]                   gx_reg, gz_reg;
    logic [ADDR_W-1:0]             row0_reg, row1_reg;
    logic [7:0]                    x1_reg;
    logic signed [HEIGHT_BITS-1:0] h00_reg, h10_reg, h01_reg, h11_reg;
    logic signed [41:0]            mul_reg;
    logic signed [HEIGHT_BITS-1:0] l0_reg, l1_reg;
    logic signed [HEIGHT_BITS-1:0] res_reg, lo_reg, hi_reg;
    logic                          stat_reg;
    logic                          pend_reg, first_reg;
    logic                          out_valid_reg;

    logic                          ram_we;
    logic [ADDR_W-1:0]             ram_addr;
    logic [HEIGHT_BITS-1:0]        ram_wdata, ram_rdata;
    logic signed [HEIGHT_BITS-1:0] rd_s;
    logic                          in_grid;
    logic [16:0]                   cell_idx;
    logic [7:0]                    x0, z0, z1;
    logic [DIM_W-1:0]              x0p1, z0p1;
    logic signed [24:0]            diff_a, diff_b, diff_c;
    logic signed [41:0]            shifted;
    logic [CNT_W-1:0]              last_idx;

    hmbs_ram #(.WIDTH(HEIGHT_BITS), .DEPTH(STORE_DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign rd_s     = $signed(ram_rdata);
    assign in_grid  = ({1'b0, item_reg.cx} < eff_w) && ({1'b0, item_reg.cz} < eff_h);
    assign cell_idx = 17'(item_reg.cz * eff_w) + 17'(item_reg.cx);
    assign x0       = gx_reg[23:16];
    assign z0       = gz_reg[23:16];
    assign x0p1     = DIM_W'(x0) + DIM_W'(1);
    assign z0p1     = DIM_W'(z0) + DIM_W'(1);
    assign z1       = (z0p1 < eff_h) ? z0p1[7:0] : 8'(eff_h - DIM_W'(1));
    assign diff_a   = 25'(h10_reg) - 25'(h00_reg);
    assign diff_b   = 25'(h11_reg) - 25'(h01_reg);
    assign diff_c   = 25'(l1_reg) - 25'(l0_reg);
    assign shifted  = mul_reg >>> 16;
    assign last_idx = n_reg - CNT_W'(1);

    assign q_pop          = (state_reg == S_IDLE) && q_valid;
    assign bstat.clearing = (state_reg == S_CLEAR);
    assign out_valid      = out_valid_reg;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = addr_reg;
        ram_wdata = item_reg.hv;
        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = cnt_reg[ADDR_W-1:0];
                ram_wdata = '0;
            end
            S_WR:   ram_we = 1'b1;
            S_FILL:
            begin
                ram_we   = 1'b1;
                ram_addr = cnt_reg[ADDR_W-1:0];
            end
            S_SCAN: ram_addr = cnt_reg[ADDR_W-1:0];
            S_RA:   ram_addr = row0_reg + ADDR_W'(x0);
            S_RB:   ram_addr = row0_reg + ADDR_W'(x1_reg);
            S_RC:   ram_addr = row1_reg + ADDR_W'(x0);
            S_RD:   ram_addr = row1_reg + ADDR_W'(x1_reg);
            default: ram_addr = addr_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        n_reg <= CNT_W'(eff_w * eff_h);
        if (q_pop)
            item_reg <= q_item;
        case (state_reg)
            S_MULX: prod_reg <= item_reg.wx * $signed({1'b0, inv_w});
            S_MULZ:
            begin
                gx_reg   <= grid_clamp(prod_reg, eff_w);
                prod_reg <= item_reg.wz * $signed({1'b0, inv_h});
            end
            S_CLZ:  gz_reg <= grid_clamp(prod_reg, eff_h);
            S_ROWS:
            begin
                row0_reg <= ADDR_W'(z0 * eff_w);
                row1_reg <= ADDR_W'(z1 * eff_w);
                x1_reg   <= (x0p1 < eff_w) ? x0p1[7:0] : 8'(eff_w - DIM_W'(1));
            end
            S_RB:   h00_reg <= rd_s;
            S_RC:   h10_reg <= rd_s;
            S_RD:   h01_reg <= rd_s;
            S_L0:
            begin
                h11_reg <= rd_s;
                mul_reg <= diff_a * $signed({1'b0, gx_reg[15:0]});
            end
            S_L1:
            begin
                l0_reg  <= h00_reg + shifted[23:0];
                mul_reg <= diff_b * $signed({1'b0, gx_reg[15:0]});
            end
            S_L2:   l1_reg <= h01_reg + shifted[23:0];
            S_L3:   mul_reg <= diff_c * $signed({1'b0, gz_reg[15:0]});
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            addr_reg      <= '0;
            res_reg       <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            stat_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            result_height <= '0;
            min_height    <= '0;
            max_height    <= '0;
            status        <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            // scan reads land in the cycle after their address
            pend_reg <= (state_reg == S_SCAN);
            if (pend_reg)
            begin
                first_reg <= 1'b0;
                if (first_reg || rd_s < lo_reg)
                    lo_reg <= rd_s;
                if (first_reg || rd_s > hi_reg)
                    hi_reg <= rd_s;
            end

            case (state_reg)
                S_CLEAR:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(STORE_DEPTH - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    res_reg  <= '0;
                    lo_reg   <= '0;
                    hi_reg   <= '0;
                    stat_reg <= 1'b0;
                    cnt_reg  <= '0;
                    if (q_valid)
                        state_reg <= S_DISP;
                end
                S_DISP:
                begin
                    addr_reg  <= cell_idx[ADDR_W-1:0];
                    first_reg <= 1'b1;
                    case (item_reg.op)
                        OP_WRITE:
                        begin
                            stat_reg  <= !in_grid;
                            state_reg <= in_grid ? S_WR : S_FIN;
                        end
                        OP_READ:
                        begin
                            stat_reg  <= !in_grid;
                            state_reg <= in_grid ? S_RD0 : S_FIN;
                        end
                        OP_SAMPLE: state_reg <= (n_reg == '0) ? S_FIN : S_MULX;
                        OP_FILL:   state_reg <= (n_reg == '0) ? S_FIN : S_FILL;
                        OP_SCAN:   state_reg <= (n_reg == '0) ? S_FIN : S_SCAN;
                        default:   state_reg <= S_FIN;
                    endcase
                end
                S_WR:   state_reg <= S_FIN;
                S_RD0:  state_reg <= S_RD1;
                S_RD1:
                begin
                    res_reg   <= rd_s;
                    state_reg <= S_FIN;
                end
                S_FILL:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == last_idx)
                        state_reg <= S_FIN;
                end
                S_SCAN:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == last_idx)
                        state_reg <= S_SCANW;
                end
                S_SCANW: state_reg <= S_FIN;
                S_MULX:  state_reg <= S_MULZ;
                S_MULZ:  state_reg <= S_CLZ;
                S_CLZ:   state_reg <= S_ROWS;
                S_ROWS:  state_reg <= S_RA;
                S_RA:    state_reg <= S_RB;
                S_RB:    state_reg <= S_RC;
                S_RC:    state_reg <= S_RD;
                S_RD:    state_reg <= S_L0;
                S_L0:    state_reg <= S_L1;
                S_L1:    state_reg <= S_L2;
                S_L2:    state_reg <= S_L3;
                S_L3:    state_reg <= S_L4;
                S_L4:
                begin
                    res_reg   <= l0_reg + shifted[23:0];
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (!out_valid_reg)
                    begin
                        result_height <= res_reg;
                        min_height    <= lo_reg;
                        max_height    <= hi_reg;
                        status        <= stat_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !q_pop)
        else $error("item taken during clearing pass");
    a_we_states: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_CLEAR || state_reg == S_WR || state_reg == S_FILL))
        else $error("store written outside a write state");
    a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && !out_valid_reg) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("result not presented on finish");

endmodule

### hw/rtl/heightmap_bilinear_sampler.sv
// Height grid store with write, read, fill, min/max scan and bilinear sample.
// The single-port store serves one access per cycle, and a sample takes four reads.
// One word is in execution at a time; a two-word queue keeps the input open meanwhile.
// Reset (rst_n, async low) clears config to defaults and starts a clearing pass over
// all 65536 store words; the input stalls until it finishes.
// Depends on hmbs_pkg, hmbs_front, hmbs_back, hmbs_ram.
module heightmap_bilinear_sampler import hmbs_pkg::*; (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [2:0]                     cfg_index,
    input  logic [INV_W-1:0]               cfg_data,
    // input words
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [2:0]                     command,
    input  logic [CX_W-1:0]                cell_x,
    input  logic [CX_W-1:0]                cell_z,
    input  logic signed [HEIGHT_BITS-1:0]  height_value,
    input  logic signed [31:0]             world_x,
    input  logic signed [31:0]             world_z,
    // result words
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [HEIGHT_BITS-1:0]  result_height,
    output logic signed [HEIGHT_BITS-1:0]  min_height,
    output logic signed [HEIGHT_BITS-1:0]  max_height,
    output logic                           status
);

    logic [DIM_W-1:0] grid_width_reg, grid_height_reg;
    logic [INV_W-1:0] inv_w_reg, inv_h_reg;
    logic [DIM_W-1:0] eff_w, eff_h;
    logic             q_valid, q_pop;
    item_t            q_item;
    back_status_t     bstat;

    // config registers; writes must arrive only while idle; the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= '0;
            grid_height_reg <= '0;
            inv_w_reg       <= INV_W'(65536);
            inv_h_reg       <= INV_W'(65536);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_data[DIM_W-1:0];
                REG_GRID_HEIGHT: grid_height_reg <= cfg_data[DIM_W-1:0];
                REG_INV_BLOCK_W: inv_w_reg       <= cfg_data;
                REG_INV_BLOCK_H: inv_h_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    // oversized dimensions act as the maximum
    assign eff_w = (grid_width_reg > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : grid_width_reg;
    assign eff_h = (grid_height_reg > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT)
                                                           : grid_height_reg;

    hmbs_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .cell_x       (cell_x),
        .cell_z       (cell_z),
        .height_value (height_value),
        .world_x      (world_x),
        .world_z      (world_z),
        .bstat        (bstat),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    hmbs_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .eff_w         (eff_w),
        .eff_h         (eff_h),
        .inv_w         (inv_w_reg),
        .inv_h         (inv_h_reg),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .bstat         (bstat),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_height (result_height),
        .min_height    (min_height),
        .max_height    (max_height),
        .status        (status)
    );

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for heightmap_bilinear_sampler: write, read, fill, scan and sample.
// Holds its own copy of the grid and config, predicts each result word, checks in order.
// Depends on hmbs_pkg and the RTL of heightmap_bilinear_sampler.
`timescale 1ns / 1ps

module testbench;
    import hmbs_pkg::*;

    // index past the four registers; writes there must be ignored
    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int TARGET_ITEMS = 1250;

    typedef struct {
        logic [2:0]         cmd;
        logic [7:0]         cx;
        logic [7:0]         cz;
        logic signed [23:0] hv;
        logic signed [31:0] wx;
        logic signed [31:0] wz;
    } grid_cmd_t;

    typedef struct {
        logic signed [23:0] res;
        logic signed [23:0] lo;
        logic signed [23:0] hi;
        logic               st;
    } grid_reply_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [2:0]             cfg_index = '0;
    logic [INV_W-1:0]       cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [2:0]             command = '0;
    logic [7:0]             cell_x = '0;
    logic [7:0]             cell_z = '0;
    logic signed [23:0]     height_value = '0;
    logic signed [31:0]     world_x = '0;
    logic signed [31:0]     world_z = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b1;
    logic signed [23:0]     result_height;
    logic signed [23:0]     min_height;
    logic signed [23:0]     max_height;
    logic                   status;

    heightmap_bilinear_sampler dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .cell_x(cell_x), .cell_z(cell_z),
        .height_value(height_value), .world_x(world_x), .world_z(world_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_height(result_height), .min_height(min_height),
        .max_height(max_height), .status(status)
    );

    always #5 clk = ~clk;

    // ---------------------------------------------------------------
    // Predictor state: grid contents and register copies
    // ---------------------------------------------------------------
    logic signed [23:0] grid_mem [0:STORE_DEPTH-1];
    int unsigned        grid_w, grid_h;
    longint             inv_w, inv_h;

    grid_cmd_t   cmd_queue[$];      // words waiting to be driven
    grid_reply_t reply_queue[$];    // predicted result words, oldest first
    int          words_queued, words_sent, replies_checked, errors;
    int          cmd_count [8];
    bit          quiet;             // phase without idling on either side

    function automatic int unsigned used_w();
        return (grid_w > MAX_WIDTH) ? MAX_WIDTH : grid_w;
    endfunction

    function automatic int unsigned used_h();
        return (grid_h > MAX_HEIGHT) ? MAX_HEIGHT : grid_h;
    endfunction

    // world (Q16.16) times reciprocal (Q8.16) -> Q.16 grid position, clamped
    function automatic longint grid_pos(longint world, longint inv, int unsigned n);
        longint p, g, lim;
        p   = world * inv;
        lim = longint'(n - 1) <<< 16;
        if (p <= 0)
            return 0;
        g = p >>> 16;
        return (g > lim) ? lim : g;
    endfunction

    function automatic longint blend(longint a, longint b, longint t);
        return a + (((b - a) * t) >>> 16);
    endfunction

    function automatic longint interp_height(longint wx, longint wz);
        int unsigned w, h, x0, z0, x1, z1;
        longint      gx, gz, tx, tz, top, bot;
        w = used_w();
        h = used_h();
        if (w == 0 || h == 0)
            return 0;
        gx = grid_pos(wx, inv_w, w);
        gz = grid_pos(wz, inv_h, h);
        x0 = gx >> 16;
        z0 = gz >> 16;
        tx = gx & 16'hFFFF;
        tz = gz & 16'hFFFF;
        x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
        z1 = (z0 + 1 < h) ? z0 + 1 : h - 1;
        top = blend(grid_mem[z0*w + x0], grid_mem[z0*w + x1], tx);
        bot = blend(grid_mem[z1*w + x0], grid_mem[z1*w + x1], tx);
        return blend(top, bot, tz);
    endfunction

    // apply one accepted word to the grid copy and queue its expected reply
    task automatic apply_grid_cmd(grid_cmd_t c);
        grid_reply_t r;
        int unsigned w, h, n;
        bit          in_grid;
        w = used_w();
        h = used_h();
        n = w * h;
        in_grid = (c.cx < w) && (c.cz < h);
        r = '{res: '0, lo: '0, hi: '0, st: 1'b0};
        case (c.cmd)
            CMD_WRITE:
                if (in_grid)
                    grid_mem[c.cz*w + c.cx] = c.hv;
                else
                    r.st = 1'b1;
            CMD_READ:
                if (in_grid)
                    r.res = grid_mem[c.cz*w + c.cx];
                else
                    r.st = 1'b1;
            CMD_SAMPLE:
                r.res = 24'(interp_height(c.wx, c.wz));
            CMD_FILL:
                for (int unsigned i = 0; i < n; i++)
                    grid_mem[i] = c.hv;
            CMD_SCAN:
                if (n > 0)
                begin
                    r.lo = grid_mem[0];
                    r.hi = grid_mem[0];
                    for (int unsigned i = 1; i < n; i++)
                    begin
                        if (grid_mem[i] < r.lo) r.lo = grid_mem[i];
                        if (grid_mem[i] > r.hi) r.hi = grid_mem[i];
                    end
                end
            default: ;  // unknown commands: no change, all zero
        endcase
        cmd_count[c.cmd]++;
        reply_queue.push_back(r);
    endtask

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int k;
        if (quiet)
            return 0;
        k = $urandom_range(0, 99);
        if (k < 60) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ---------------------------------------------------------------
    // Driver: offers words from cmd_queue, predicts on acceptance
    // ---------------------------------------------------------------
    grid_cmd_t drv_word;
    int        drv_gap;

    always @(posedge clk or negedge rst_n)
    begin
        bit hold_valid;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            drv_gap  = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                apply_grid_cmd(drv_word);
                words_sent++;
            end
            // a stalled word stays on the port unchanged
            hold_valid = in_valid && in_stall;
            if (!hold_valid)
            begin
                if (drv_gap > 0)
                    drv_gap--;
                else if (cmd_queue.size() > 0)
                begin
                    drv_word     = cmd_queue.pop_front();
                    command      <= drv_word.cmd;
                    cell_x       <= drv_word.cx;
                    cell_z       <= drv_word.cz;
                    height_value <= drv_word.hv;
                    world_x      <= drv_word.wx;
                    world_z      <= drv_word.wz;
                    hold_valid   = 1'b1;
                    drv_gap      = pick_gap();
                end
            end
            in_valid <= hold_valid;
        end
    end

    // ---------------------------------------------------------------
    // Monitor: random stalls, one long hold-off, in-order checking
    // ---------------------------------------------------------------
    int mon_gap, hold_left;
    bit hold_done;

    always @(posedge clk or negedge rst_n)
    begin
        grid_reply_t e;
        if (!rst_n)
        begin
            out_stall <= 1'b1;
            mon_gap   = 0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (reply_queue.size() == 0)
                begin
                    $display("%0t: result word with nothing expected (res %0d)",
                             $time, result_height);
                    errors++;
                end
                else
                begin
                    e = reply_queue.pop_front();
                    replies_checked++;
                    if (result_height !== e.res)
                    begin
                        $display("%0t: result_height expected %0d got %0d",
                                 $time, e.res, result_height);
                        errors++;
                    end
                    if (min_height !== e.lo)
                    begin
                        $display("%0t: min_height expected %0d got %0d",
                                 $time, e.lo, min_height);
                        errors++;
                    end
                    if (max_height !== e.hi)
                    begin
                        $display("%0t: max_height expected %0d got %0d",
                                 $time, e.hi, max_height);
                        errors++;
                    end
                    if (status !== e.st)
                    begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, e.st, status);
                        errors++;
                    end
                end
            end
            // once, well into the random part, stop draining for a long stretch
            // so the internal queue fills and in_stall rises while words keep coming
            if (!hold_done && words_sent >= 400)
            begin
                hold_done = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (mon_gap > 0)
            begin
                mon_gap--;
                out_stall <= 1'b1;
            end
            else
            begin
                mon_gap = pick_gap();
                out_stall <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    task automatic post(logic [2:0] cmd, logic [7:0] cx, logic [7:0] cz,
                        logic signed [23:0] hv, logic signed [31:0] wx,
                        logic signed [31:0] wz);
        grid_cmd_t c;
        c = '{cmd: cmd, cx: cx, cz: cz, hv: hv, wx: wx, wz: wz};
        cmd_queue.push_back(c);
        words_queued++;
    endtask

    // block until every queued word has its reply checked, then settle
    task automatic drain();
        while (replies_checked != words_queued)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // write all four registers on consecutive edges; only called while idle
    task automatic set_regs(int unsigned w, int unsigned h, int unsigned iw,
                            int unsigned ih);
        logic [2:0]       idx [4];
        logic [INV_W-1:0] val [4];
        idx = '{REG_GRID_WIDTH, REG_GRID_HEIGHT, REG_INV_BLOCK_W, REG_INV_BLOCK_H};
        val = '{INV_W'(w), INV_W'(h), INV_W'(iw), INV_W'(ih)};
        for (int i = 0; i < 4; i++)
        begin
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
        end
        if ($urandom_range(0, 2) == 0)
        begin
            @(posedge clk);
            cfg_index <= REG_UNUSED;
            cfg_data  <= INV_W'($urandom);
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        grid_w = w & 9'h1FF;
        grid_h = h & 9'h1FF;
        inv_w  = iw & 24'hFFFFFF;
        inv_h  = ih & 24'hFFFFFF;
    endtask

    // world coordinate aimed mostly inside the grid for the current scale
    function automatic logic signed [31:0] aim_world(longint inv, int unsigned n);
        longint tgt, wv;
        if ($urandom_range(0, 4) == 0)
            return $urandom;
        tgt = longint'($urandom_range(0, (n + 3) << 16)) - (longint'(2) << 16);
        wv  = (tgt <<< 16) / inv;
        if (wv > 64'sh7FFFFFFF)  wv = 64'sh7FFFFFFF;
        if (wv < -64'sh80000000) wv = -64'sh80000000;
        return 32'(wv);
    endfunction

    function automatic logic [7:0] aim_cell(int unsigned n);
        if (n == 0 || $urandom_range(0, 6) == 0)
            return 8'($urandom);
        return 8'($urandom_range(0, n - 1));
    endfunction

    task automatic random_word();
        int unsigned w, h, k;
        logic [2:0]  cmd;
        w = used_w();
        h = used_h();
        k = $urandom_range(0, 99);
        if (k < 33)      cmd = CMD_WRITE;
        else if (k < 56) cmd = CMD_READ;
        else if (k < 84) cmd = CMD_SAMPLE;
        else if (k < 89) cmd = CMD_FILL;
        else if (k < 95) cmd = CMD_SCAN;
        else             cmd = 3'($urandom_range(CMD_SCAN + 1, 7));
        post(cmd, aim_cell(w), aim_cell(h), 24'($urandom),
             aim_world(inv_w, w), aim_world(inv_h, h));
    endtask

    function automatic int unsigned pick_inv();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return 1;
        if (k == 1) return 24'hFFFFFF;
        if (k < 5)  return 65536;
        return $urandom_range(8192, 524288);
    endfunction

    initial
    begin
        int unsigned w, h;
        int          burst;
        for (int i = 0; i < STORE_DEPTH; i++)
            grid_mem[i] = '0;
        grid_w = 0;
        grid_h = 0;
        inv_w  = 65536;
        inv_h  = 65536;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // empty grid after reset: everything out of range or zero
        quiet = 1'b0;
        post(CMD_WRITE, '0, '0, 24'sd5, '0, '0);
        post(CMD_READ, '0, '0, '0, '0, '0);
        post(CMD_SAMPLE, '0, '0, '0, 32'sh00018000, 32'sh00018000);
        post(CMD_FILL, '0, '0, 24'sd77, '0, '0);
        post(CMD_SCAN, '0, '0, '0, '0, '0);
        for (int c = CMD_SCAN + 1; c < 8; c++)
            post(3'(c), 8'hFF, 8'hFF, 24'sh7FFFFF, -32'sd1, -32'sd1);
        drain();

        // full grid, width register above the maximum
        set_regs(300, 256, 65536, 65536);
        post(CMD_FILL, '0, '0, 24'sh7FFFFF, '0, '0);
        post(CMD_SCAN, '0, '0, '0, '0, '0);
        post(CMD_WRITE, '0, '0, -24'sh800000, '0, '0);
        post(CMD_WRITE, 8'd255, 8'd255, -24'sd1, '0, '0);
        post(CMD_WRITE, 8'd254, 8'd255, 24'sh7FFFFF, '0, '0);
        post(CMD_WRITE, 8'd1, '0, 24'sh7FFFFF, '0, '0);
        post(CMD_READ, 8'd255, 8'd255, '0, '0, '0);
        post(CMD_READ, '0, '0, '0, '0, '0);
        post(CMD_SAMPLE, '0, '0, '0, 32'sh00008000, 32'sh00004000);
        post(CMD_SAMPLE, '0, '0, '0, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        post(CMD_SAMPLE, '0, '0, '0, 32'sh80000000, 32'sh80000000);
        post(CMD_SAMPLE, '0, '0, '0, 32'h00FEC000, 32'h00FE4000);
        post(CMD_SCAN, '0, '0, '0, '0, '0);
        drain();

        // random phases; small grids keep fill and scan short
        while (words_queued < TARGET_ITEMS)
        begin
            k_phase: begin
                int m;
                m = $urandom_range(0, 9);
                if (m == 0)
                begin
                    w = 0;
                    h = $urandom_range(0, 8);
                end
                else if (m < 7)
                begin
                    w = $urandom_range(1, 12);
                    h = $urandom_range(1, 12);
                end
                else if (m < 9)
                begin
                    w = $urandom_range(13, 511);
                    h = $urandom_range(1, 3);
                end
                else
                begin
                    w = $urandom_range(1, 3);
                    h = $urandom_range(13, 511);
                end
                if ($urandom_range(0, 1))
                begin
                    // transpose about half of all cases so both registers see large values
                    int unsigned t;
                    t = w;
                    w = h;
                    h = t;
                end
            end
            set_regs(w, h, pick_inv(), pick_inv());
            quiet = ($urandom_range(0, 5) == 0);
            burst = $urandom_range(60, 140);
            if (burst > TARGET_ITEMS - words_queued)
                burst = TARGET_ITEMS - words_queued;
            repeat (burst)
                random_word();
            drain();
        end

        $display("Covered %0d words: %0d write, %0d read, %0d sample, %0d fill, %0d scan,",
                 words_sent, cmd_count[CMD_WRITE], cmd_count[CMD_READ],
                 cmd_count[CMD_SAMPLE], cmd_count[CMD_FILL], cmd_count[CMD_SCAN]);
        $display("%0d unknown-command words, with mismatches counted: %0d",
                 cmd_count[5] + cmd_count[6] + cmd_count[7], errors);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // watchdog: clearing pass, full-grid fills/scans and every random word as a
    // long scan under the longest stalls still fit well inside this
    initial
    begin
        #100_000_000;
        $display("Timeout waiting for result words");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### heightmap_bilinear_sampler.f
hw/rtl/hmbs_pkg.sv
hw/rtl/hmbs_ram.sv
hw/rtl/hmbs_front.sv
hw/rtl/hmbs_back.sv
hw/rtl/heightmap_bilinear_sampler.sv
tb/sv/testbench.sv
